>>> src/csmc_pkg.sv
// ----------------------------------------------------------------------------
// csmc_pkg
// Shared types, codes and helpers of the clock set-mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package csmc_pkg;

  // action codes
  localparam logic [3:0] ACT_TICK     = 4'd0;
  localparam logic [3:0] ACT_PRESS    = 4'd1;
  localparam logic [3:0] ACT_SET_MODE = 4'd2;
  localparam logic [3:0] ACT_NEXT_FLD = 4'd3;
  localparam logic [3:0] ACT_PREV_FLD = 4'd4;
  localparam logic [3:0] ACT_INC      = 4'd5;
  localparam logic [3:0] ACT_DEC      = 4'd6;
  localparam logic [3:0] ACT_ACCEPT   = 4'd7;
  localparam logic [3:0] ACT_CANCEL   = 4'd8;

  // mode codes
  localparam logic [2:0] MODE_HIDDEN   = 3'd0;
  localparam logic [2:0] MODE_DETAILS  = 3'd1;
  localparam logic [2:0] MODE_BRIGHT   = 3'd2;
  localparam logic [2:0] MODE_SET_TIME = 3'd3;
  localparam logic [2:0] MODE_SET_DATE = 3'd4;

  // edit field codes
  localparam logic [1:0] FLD_HOURS   = 2'd0;
  localparam logic [1:0] FLD_MINUTES = 2'd1;
  localparam logic [1:0] FLD_SECONDS = 2'd2;
  localparam logic [1:0] FLD_WEEKDAY = 2'd0;
  localparam logic [1:0] FLD_DAY     = 2'd1;
  localparam logic [1:0] FLD_MONTH   = 2'd2;
  localparam logic [1:0] FLD_YEAR    = 2'd3;

  // commit codes
  localparam logic [1:0] COMMIT_NONE = 2'd0;
  localparam logic [1:0] COMMIT_TIME = 2'd1;
  localparam logic [1:0] COMMIT_DATE = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_SHORT_TO = 2'd0;
  localparam logic [1:0] REG_LONG_TO  = 2'd1;
  localparam logic [1:0] REG_TICK     = 2'd2;

  localparam logic [15:0] SHORT_TO_RST = 16'd3500;
  localparam logic [15:0] LONG_TO_RST  = 16'd5000;
  localparam logic [9:0]  TICK_RST     = 10'd10;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  // field limits, 7 bits so they share one wrap helper
  localparam logic [6:0] HOURS_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX  = 7'd59;
  localparam logic [6:0] WEEKDAY_MAX = 7'd6;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] BRIGHT_MAX  = 7'd100;
  localparam logic [6:0] BRIGHT_STEP = 7'd5;
  localparam logic [6:0] BRIGHT_TOP  = 7'd95;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] target_mode;
    logic [4:0] now_hours;
    logic [5:0] now_minutes;
    logic [5:0] now_seconds;
    logic [2:0] now_weekday;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [6:0] now_year;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] edit_field;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic [5:0] edit_seconds;
    logic [2:0] edit_weekday;
    logic [4:0] edit_day;
    logic [3:0] edit_month;
    logic [6:0] edit_year;
    logic [6:0] brightness;
    logic       clock_run;
    logic [1:0] commit;
  } out_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } date_t;

  // one wrapping step of a field between lo and hi
  function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi, input logic up);
    logic [6:0] r;
    if (up) begin
      r = (v < hi) ? v + 7'd1 : lo;
    end else begin
      r = (v > lo) ? v - 7'd1 : hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/csmc_date_edit.sv
// ----------------------------------------------------------------------------
// csmc_date_edit
// One increment or decrement of the selected date field, with the day
// clamped to the length of the resulting month.
// ----------------------------------------------------------------------------
`default_nettype none

module csmc_date_edit
  import csmc_pkg::*;
(
  input  wire date_t       date_i,
  input  wire logic [1:0]  field_i,
  input  wire logic        up_i,
  output date_t            date_o
);

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [6:0] yr);
    logic [4:0] len;
    case (mon) inside
      4'd2:                   len = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  logic [4:0] cur_len;
  logic [4:0] new_len;
  logic [6:0] step;
  date_t      edited;

  assign cur_len = month_len(date_i.month, date_i.year);

  always_comb begin
    edited = date_i;
    step   = 7'd0;
    case (field_i)
      FLD_WEEKDAY: begin
        step           = wrap_step({4'd0, date_i.weekday}, 7'd0, WEEKDAY_MAX, up_i);
        edited.weekday = step[2:0];
      end
      FLD_DAY: begin
        step       = wrap_step({2'd0, date_i.day}, 7'd1, {2'd0, cur_len}, up_i);
        edited.day = step[4:0];
      end
      FLD_MONTH: begin
        step         = wrap_step({3'd0, date_i.month}, 7'd1, MONTH_MAX, up_i);
        edited.month = step[3:0];
      end
      default: begin
        step        = wrap_step(date_i.year, 7'd0, YEAR_MAX, up_i);
        edited.year = step;
      end
    endcase
  end

  assign new_len = month_len(edited.month, edited.year);

  always_comb begin
    date_o = edited;
    if (edited.day > new_len) begin
      date_o.day = new_len;
    end
  end

endmodule

`default_nettype wire

>>> src/clock_set_mode_controller_core.sv
// ----------------------------------------------------------------------------
// clock_set_mode_controller_core
// Mode controller of a button-driven clock: modes, field editing, brightness
// and inactivity timeout.
// ----------------------------------------------------------------------------
// One event (tick or button action) is taken per clock cycle while in_ready is
// high, and yields one result, which is registered into the output buffer. All
// state is updated in the accepting cycle by a single pass of logic, so there is
// no internal loop. Results queue in a two-entry output buffer; in_ready drops
// only when both entries are held by a stalled consumer. Configuration writes
// take effect on the next event.
`default_nettype none

module clock_set_mode_controller_core
  import csmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // config
  logic [15:0] short_to_r;
  logic [15:0] long_to_r;
  logic [9:0]  tick_r;

  // controller state
  logic [2:0]  mode_r,    mode_nxt;
  logic        counting_r, counting_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic        lt_sel_r,  lt_sel_nxt;
  logic [1:0]  field_r,   field_nxt;
  logic [4:0]  hours_r,   hours_nxt;
  logic [5:0]  minutes_r, minutes_nxt;
  logic [5:0]  seconds_r, seconds_nxt;
  date_t       date_r,    date_nxt;
  logic [6:0]  bright_r,  bright_nxt;
  logic        run_r,     run_nxt;
  logic [1:0]  commit;

  // output buffer
  out_t        buf0_r, buf0_nxt;
  out_t        buf1_r, buf1_nxt;
  logic [1:0]  cnt_r,  cnt_nxt;

  logic        in_fire;
  logic        out_fire;
  logic        up;
  logic [17:0] tick_sum;
  logic [16:0] elapsed_tick;
  logic [15:0] limit;
  logic [2:0]  nfields;
  logic [2:0]  field_inc;
  logic [6:0]  tstep;
  date_t       date_edit;
  out_t        result;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf0_r;
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;

  assign up           = (in_data.action == ACT_INC);
  assign tick_sum     = {1'b0, elapsed_r} + {8'd0, tick_r};
  assign elapsed_tick = counting_r ? (tick_sum[17] ? ELAPSED_MAX : tick_sum[16:0])
                                   : elapsed_r;
  assign limit        = lt_sel_r ? long_to_r : short_to_r;
  assign nfields      = (mode_r == MODE_SET_TIME) ? 3'd3 : 3'd4;
  assign field_inc    = {1'b0, field_r} + 3'd1;

  csmc_date_edit u_date_edit (
    .date_i  (date_r),
    .field_i (field_r),
    .up_i    (up),
    .date_o  (date_edit)
  );

  always_comb begin
    mode_nxt     = mode_r;
    counting_nxt = counting_r;
    elapsed_nxt  = elapsed_r;
    lt_sel_nxt   = lt_sel_r;
    field_nxt    = field_r;
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    seconds_nxt  = seconds_r;
    date_nxt     = date_r;
    bright_nxt   = bright_r;
    run_nxt      = run_r;
    commit       = COMMIT_NONE;
    tstep        = 7'd0;

    case (in_data.action)
      ACT_TICK: begin
        elapsed_nxt = elapsed_tick;
        if (elapsed_tick > {1'b0, limit}) begin
          mode_nxt     = MODE_HIDDEN;
          counting_nxt = 1'b0;
          elapsed_nxt  = 17'd0;
          lt_sel_nxt   = 1'b0;
          run_nxt      = 1'b1;
        end
      end
      ACT_PRESS: begin
        elapsed_nxt  = 17'd0;
        counting_nxt = 1'b1;
      end
      ACT_SET_MODE: begin
        case (in_data.target_mode)
          MODE_HIDDEN: begin
            mode_nxt     = MODE_HIDDEN;
            counting_nxt = 1'b0;
            elapsed_nxt  = 17'd0;
            lt_sel_nxt   = 1'b0;
            run_nxt      = 1'b1;
          end
          MODE_DETAILS: mode_nxt = MODE_DETAILS;
          MODE_BRIGHT:  mode_nxt = MODE_BRIGHT;
          MODE_SET_TIME: begin
            mode_nxt    = MODE_SET_TIME;
            lt_sel_nxt  = 1'b1;
            field_nxt   = FLD_HOURS;
            run_nxt     = 1'b0;
            hours_nxt   = (in_data.now_hours > HOURS_MAX[4:0]) ? HOURS_MAX[4:0]
                                                               : in_data.now_hours;
            minutes_nxt = (in_data.now_minutes > MINSEC_MAX[5:0]) ? MINSEC_MAX[5:0]
                                                                  : in_data.now_minutes;
            seconds_nxt = (in_data.now_seconds > MINSEC_MAX[5:0]) ? MINSEC_MAX[5:0]
                                                                  : in_data.now_seconds;
          end
          MODE_SET_DATE: begin
            mode_nxt   = MODE_SET_DATE;
            lt_sel_nxt = 1'b1;
            field_nxt  = FLD_WEEKDAY;
            run_nxt    = 1'b0;
            date_nxt.weekday = (in_data.now_weekday > WEEKDAY_MAX[2:0]) ? WEEKDAY_MAX[2:0]
                                                                        : in_data.now_weekday;
            date_nxt.day     = (in_data.now_day == 5'd0) ? 5'd1 : in_data.now_day;
            if (in_data.now_month == 4'd0) begin
              date_nxt.month = 4'd1;
            end else if (in_data.now_month > MONTH_MAX[3:0]) begin
              date_nxt.month = MONTH_MAX[3:0];
            end else begin
              date_nxt.month = in_data.now_month;
            end
            date_nxt.year    = (in_data.now_year > YEAR_MAX) ? YEAR_MAX : in_data.now_year;
          end
          default: ;
        endcase
      end
      ACT_NEXT_FLD, ACT_PREV_FLD: begin
        if (mode_r == MODE_SET_TIME || mode_r == MODE_SET_DATE) begin
          if (in_data.action == ACT_NEXT_FLD) begin
            field_nxt = (field_inc < nfields) ? field_inc[1:0] : FLD_HOURS;
          end else if (field_r != 2'd0 && {1'b0, field_r} < nfields) begin
            field_nxt = field_r - 2'd1;
          end else begin
            field_nxt = nfields[1:0] - 2'd1;
          end
        end
      end
      ACT_INC, ACT_DEC: begin
        case (mode_r)
          MODE_BRIGHT: begin
            if (up) begin
              if (bright_r <= BRIGHT_TOP) bright_nxt = bright_r + BRIGHT_STEP;
            end else if (bright_r >= BRIGHT_STEP) begin
              bright_nxt = bright_r - BRIGHT_STEP;
            end
          end
          MODE_SET_TIME: begin
            case (field_r)
              FLD_HOURS: begin
                tstep     = wrap_step({2'd0, hours_r}, 7'd0, HOURS_MAX, up);
                hours_nxt = tstep[4:0];
              end
              FLD_MINUTES: begin
                tstep       = wrap_step({1'b0, minutes_r}, 7'd0, MINSEC_MAX, up);
                minutes_nxt = tstep[5:0];
              end
              FLD_SECONDS: begin
                tstep       = wrap_step({1'b0, seconds_r}, 7'd0, MINSEC_MAX, up);
                seconds_nxt = tstep[5:0];
              end
              default: ;
            endcase
          end
          MODE_SET_DATE: date_nxt = date_edit;
          default: ;
        endcase
      end
      ACT_ACCEPT, ACT_CANCEL: begin
        if (in_data.action == ACT_ACCEPT) begin
          if (mode_r == MODE_SET_TIME) begin
            commit = COMMIT_TIME;
          end else if (mode_r == MODE_SET_DATE) begin
            commit = COMMIT_DATE;
          end
        end
        mode_nxt     = MODE_HIDDEN;
        counting_nxt = 1'b0;
        elapsed_nxt  = 17'd0;
        lt_sel_nxt   = 1'b0;
        run_nxt      = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.mode         = mode_nxt;
    result.edit_field   = field_nxt;
    result.edit_hours   = hours_nxt;
    result.edit_minutes = minutes_nxt;
    result.edit_seconds = seconds_nxt;
    result.edit_weekday = date_nxt.weekday;
    result.edit_day     = date_nxt.day;
    result.edit_month   = date_nxt.month;
    result.edit_year    = date_nxt.year;
    result.brightness   = bright_nxt;
    result.clock_run    = run_nxt;
    result.commit       = commit;
  end

  // two-entry output queue, head in buf0
  always_comb begin
    buf0_nxt = buf0_r;
    buf1_nxt = buf1_r;
    cnt_nxt  = cnt_r;
    if (in_fire && !out_fire) begin
      if (cnt_r == 2'd0) begin
        buf0_nxt = result;
      end else begin
        buf1_nxt = result;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (!in_fire && out_fire) begin
      buf0_nxt = buf1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (in_fire && out_fire) begin
      if (cnt_r == 2'd1) begin
        buf0_nxt = result;
      end else begin
        buf0_nxt = buf1_r;
        buf1_nxt = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_to_r <= SHORT_TO_RST;
      long_to_r  <= LONG_TO_RST;
      tick_r     <= TICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_TO: short_to_r <= cfg_wdata;
        REG_LONG_TO:  long_to_r  <= cfg_wdata;
        REG_TICK:     tick_r     <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HIDDEN;
      counting_r <= 1'b0;
      elapsed_r  <= 17'd0;
      lt_sel_r   <= 1'b0;
      field_r    <= 2'd0;
      hours_r    <= 5'd0;
      minutes_r  <= 6'd0;
      seconds_r  <= 6'd0;
      date_r     <= '{weekday: 3'd0, day: 5'd1, month: 4'd1, year: 7'd0};
      bright_r   <= BRIGHT_MAX;
      run_r      <= 1'b1;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      counting_r <= counting_nxt;
      elapsed_r  <= elapsed_nxt;
      lt_sel_r   <= lt_sel_nxt;
      field_r    <= field_nxt;
      hours_r    <= hours_nxt;
      minutes_r  <= minutes_nxt;
      seconds_r  <= seconds_nxt;
      date_r     <= date_nxt;
      bright_r   <= bright_nxt;
      run_r      <= run_nxt;
    end
  end

  // clock runs exactly when the short timeout is in use
  a_run_vs_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    run_r != lt_sel_r)
    else $error("run flag and timeout select out of step");

  a_commit_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.commit != COMMIT_NONE |-> out_data.mode == MODE_HIDDEN)
    else $error("commit reported outside hidden mode");

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    bright_r <= BRIGHT_MAX)
    else $error("brightness above limit");

  a_cancel_hides: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.action == ACT_CANCEL |=> mode_r == MODE_HIDDEN && run_r)
    else $error("cancel did not return to hidden");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue overflow");

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock set-mode controller core. A directed
// script covers reset values, field extremes, the ignored codes, saturation
// on load, field wrap and the leap-year day clamp. Random phases follow, each
// with its own timeout and tick settings. Every transfer in is run through a
// local model of the controller, and every transfer out is compared with the
// oldest predicted view, field by field.
// ----------------------------------------------------------------------------
module tb;
  import csmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] ACT_UNUSED_TOP  = 4'hF;
  localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;
  localparam int PHASE_ITEMS = 160;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    in_t  ev;
    bit   pinned;
    out_t want;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // expectation that travels with the item currently offered
  bit   cur_pinned;
  out_t cur_want;

  out_t      views_due[$];
  step_row_t script[$];
  int        mismatches;
  int        results_seen;
  int        idle_cycles;

  // model state
  logic [2:0]  p_mode;
  logic        p_counting;
  int unsigned p_elapsed;
  logic        p_long_sel;
  logic [1:0]  p_field;
  logic [4:0]  p_hours;
  logic [5:0]  p_minutes;
  logic [5:0]  p_seconds;
  logic [2:0]  p_weekday;
  logic [4:0]  p_day;
  logic [3:0]  p_month;
  logic [6:0]  p_year;
  logic [6:0]  p_bright;
  logic        p_run;
  int unsigned cfg_short;
  int unsigned cfg_long;
  int unsigned cfg_tick;

  clock_set_mode_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_model();
    cfg_short  = 3500;
    cfg_long   = 5000;
    cfg_tick   = 10;
    p_mode     = MODE_HIDDEN;
    p_counting = 1'b0;
    p_elapsed  = 0;
    p_long_sel = 1'b0;
    p_field    = 2'd0;
    p_hours    = '0;
    p_minutes  = '0;
    p_seconds  = '0;
    p_weekday  = '0;
    p_day      = 5'd1;
    p_month    = 4'd1;
    p_year     = '0;
    p_bright   = 7'd100;
    p_run      = 1'b1;
  endfunction

  function automatic void drop_to_hidden();
    p_mode     = MODE_HIDDEN;
    p_counting = 1'b0;
    p_elapsed  = 0;
    p_long_sel = 1'b0;
    p_run      = 1'b1;
  endfunction

  function automatic int unsigned month_days();
    case (p_month)
      4'd2: return (p_year % 4 == 0) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned step_wrap(int unsigned v, int unsigned lo,
                                            int unsigned hi, bit up);
    if (up) begin
      return (v < hi) ? v + 1 : lo;
    end
    return (v > lo) ? v - 1 : hi;
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // applies one event to the model and returns the view the core should show
  function automatic out_t advance_controller(in_t ev);
    int unsigned nf;
    int unsigned lim;
    bit          up;
    logic [1:0]  commit_code;
    out_t        v;
    commit_code = COMMIT_NONE;
    nf = (p_mode == MODE_SET_TIME) ? 3 : 4;
    up = (ev.action == ACT_INC);
    case (ev.action)
      ACT_TICK: begin
        if (p_counting) begin
          p_elapsed = (p_elapsed + cfg_tick > ELAPSED_MAX) ? ELAPSED_MAX
                                                           : p_elapsed + cfg_tick;
        end
        lim = p_long_sel ? cfg_long : cfg_short;
        if (p_elapsed > lim) drop_to_hidden();
      end
      ACT_PRESS: begin
        p_elapsed  = 0;
        p_counting = 1'b1;
      end
      ACT_SET_MODE: begin
        case (ev.target_mode)
          MODE_HIDDEN:  drop_to_hidden();
          MODE_DETAILS: p_mode = MODE_DETAILS;
          MODE_BRIGHT:  p_mode = MODE_BRIGHT;
          MODE_SET_TIME: begin
            p_mode     = MODE_SET_TIME;
            p_long_sel = 1'b1;
            p_field    = FLD_HOURS;
            p_hours    = 5'(clamp(ev.now_hours, 0, 23));
            p_minutes  = 6'(clamp(ev.now_minutes, 0, 59));
            p_seconds  = 6'(clamp(ev.now_seconds, 0, 59));
            p_run      = 1'b0;
          end
          MODE_SET_DATE: begin
            p_mode     = MODE_SET_DATE;
            p_long_sel = 1'b1;
            p_field    = FLD_WEEKDAY;
            p_weekday  = 3'(clamp(ev.now_weekday, 0, 6));
            p_day      = 5'(clamp(ev.now_day, 1, 31));
            p_month    = 4'(clamp(ev.now_month, 1, 12));
            p_year     = 7'(clamp(ev.now_year, 0, 99));
            p_run      = 1'b0;
          end
          default: ;
        endcase
      end
      ACT_NEXT_FLD, ACT_PREV_FLD: begin
        if (p_mode == MODE_SET_TIME || p_mode == MODE_SET_DATE) begin
          if (ev.action == ACT_NEXT_FLD) begin
            p_field = (p_field + 1 < nf) ? 2'(p_field + 1) : 2'd0;
          end else begin
            p_field = (p_field > 0 && p_field < nf) ? p_field - 2'd1 : 2'(nf - 1);
          end
        end
      end
      ACT_INC, ACT_DEC: begin
        if (p_mode == MODE_BRIGHT) begin
          if (up) begin
            if (p_bright <= 95) p_bright = p_bright + 7'd5;
          end else if (p_bright >= 5) begin
            p_bright = p_bright - 7'd5;
          end
        end else if (p_mode == MODE_SET_TIME) begin
          case (p_field)
            FLD_HOURS:   p_hours = 5'(step_wrap(p_hours, 0, 23, up));
            FLD_MINUTES: p_minutes = 6'(step_wrap(p_minutes, 0, 59, up));
            FLD_SECONDS: p_seconds = 6'(step_wrap(p_seconds, 0, 59, up));
            default: ;
          endcase
        end else if (p_mode == MODE_SET_DATE) begin
          case (p_field)
            FLD_WEEKDAY: p_weekday = 3'(step_wrap(p_weekday, 0, 6, up));
            FLD_DAY:     p_day = 5'(step_wrap(p_day, 1, month_days(), up));
            FLD_MONTH:   p_month = 4'(step_wrap(p_month, 1, 12, up));
            default:     p_year = 7'(step_wrap(p_year, 0, 99, up));
          endcase
          // day follows the month length after any date edit
          if (p_day > month_days()) p_day = 5'(month_days());
        end
      end
      ACT_ACCEPT: begin
        if (p_mode == MODE_SET_TIME) commit_code = COMMIT_TIME;
        else if (p_mode == MODE_SET_DATE) commit_code = COMMIT_DATE;
        drop_to_hidden();
      end
      ACT_CANCEL: drop_to_hidden();
      default: ;
    endcase
    v.mode         = p_mode;
    v.edit_field   = p_field;
    v.edit_hours   = p_hours;
    v.edit_minutes = p_minutes;
    v.edit_seconds = p_seconds;
    v.edit_weekday = p_weekday;
    v.edit_day     = p_day;
    v.edit_month   = p_month;
    v.edit_year    = p_year;
    v.brightness   = p_bright;
    v.clock_run    = p_run;
    v.commit       = commit_code;
    return v;
  endfunction

  function automatic in_t make_event(logic [3:0] a, logic [2:0] t, logic [4:0] h,
                                     logic [5:0] m, logic [5:0] s, logic [2:0] wd,
                                     logic [4:0] d, logic [3:0] mo, logic [6:0] y);
    in_t ev;
    ev.action      = a;
    ev.target_mode = t;
    ev.now_hours   = h;
    ev.now_minutes = m;
    ev.now_seconds = s;
    ev.now_weekday = wd;
    ev.now_day     = d;
    ev.now_month   = mo;
    ev.now_year    = y;
    return ev;
  endfunction

  function automatic in_t plain(logic [3:0] a, logic [2:0] t = MODE_HIDDEN);
    return make_event(a, t, 5'd12, 6'd34, 6'd56, 3'd2, 5'd15, 4'd6, 7'd24);
  endfunction

  function automatic out_t make_view(logic [2:0] md, logic [1:0] fld, logic [4:0] h,
                                     logic [5:0] m, logic [5:0] s, logic [2:0] wd,
                                     logic [4:0] d, logic [3:0] mo, logic [6:0] y,
                                     logic [6:0] br, logic run, logic [1:0] cm);
    out_t v;
    v.mode         = md;
    v.edit_field   = fld;
    v.edit_hours   = h;
    v.edit_minutes = m;
    v.edit_seconds = s;
    v.edit_weekday = wd;
    v.edit_day     = d;
    v.edit_month   = mo;
    v.edit_year    = y;
    v.brightness   = br;
    v.clock_run    = run;
    v.commit       = cm;
    return v;
  endfunction

  function automatic void add_row(in_t ev, bit pinned = 1'b0, out_t want = '0);
    step_row_t row;
    row.ev     = ev;
    row.pinned = pinned;
    row.want   = want;
    script.push_back(row);
  endfunction

  // mostly in range, sometimes any value the field width allows
  function automatic int unsigned rand_field(int unsigned lo, int unsigned hi, int w);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, (1 << w) - 1);
    return $urandom_range(lo, hi);
  endfunction

  function automatic in_t rand_event();
    in_t ev;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 30)      ev.action = ACT_TICK;
    else if (r < 38) ev.action = ACT_PRESS;
    else if (r < 52) ev.action = ACT_SET_MODE;
    else if (r < 60) ev.action = ACT_NEXT_FLD;
    else if (r < 66) ev.action = ACT_PREV_FLD;
    else if (r < 79) ev.action = ACT_INC;
    else if (r < 88) ev.action = ACT_DEC;
    else if (r < 93) ev.action = ACT_ACCEPT;
    else if (r < 97) ev.action = ACT_CANCEL;
    else             ev.action = 4'($urandom_range(ACT_CANCEL + 1, ACT_UNUSED_TOP));
    r = $urandom_range(0, 99);
    if (r < 8)       ev.target_mode = 3'($urandom_range(MODE_SET_DATE + 1, MODE_UNUSED_TOP));
    else if (r < 18) ev.target_mode = MODE_HIDDEN;
    else if (r < 28) ev.target_mode = MODE_DETAILS;
    else if (r < 43) ev.target_mode = MODE_BRIGHT;
    else if (r < 71) ev.target_mode = MODE_SET_TIME;
    else             ev.target_mode = MODE_SET_DATE;
    ev.now_hours   = 5'(rand_field(0, 23, 5));
    ev.now_minutes = 6'(rand_field(0, 59, 6));
    ev.now_seconds = 6'(rand_field(0, 59, 6));
    ev.now_weekday = 3'(rand_field(0, 6, 3));
    ev.now_day     = 5'(rand_field(1, 31, 5));
    ev.now_month   = 4'(rand_field(1, 12, 4));
    ev.now_year    = 7'(rand_field(0, 99, 7));
    return ev;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic offer(in_t ev, bit pinned, out_t want);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_data    <= ev;
    cur_pinned <= pinned;
    cur_want   <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (views_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_timeouts(logic [15:0] short_ms, logic [15:0] long_ms,
                                  logic [9:0] tick);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHORT_TO;
    cfg_wdata <= short_ms;
    @(negedge clk);
    cfg_index <= REG_LONG_TO;
    cfg_wdata <= long_ms;
    @(negedge clk);
    cfg_index <= REG_TICK;
    cfg_wdata <= {6'd0, tick};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // scoreboard: transfers in feed the model, transfers out are compared
  always @(posedge clk) begin : scoreboard
    out_t want;
    out_t got;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHORT_TO: cfg_short = 32'(cfg_wdata);
          REG_LONG_TO:  cfg_long = 32'(cfg_wdata);
          REG_TICK:     cfg_tick = 32'(cfg_wdata[9:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got = out_data;
        if (views_due.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = views_due.pop_front();
          check_field("mode", 32'(want.mode), 32'(got.mode));
          check_field("edit_field", 32'(want.edit_field), 32'(got.edit_field));
          check_field("edit_hours", 32'(want.edit_hours), 32'(got.edit_hours));
          check_field("edit_minutes", 32'(want.edit_minutes), 32'(got.edit_minutes));
          check_field("edit_seconds", 32'(want.edit_seconds), 32'(got.edit_seconds));
          check_field("edit_weekday", 32'(want.edit_weekday), 32'(got.edit_weekday));
          check_field("edit_day", 32'(want.edit_day), 32'(got.edit_day));
          check_field("edit_month", 32'(want.edit_month), 32'(got.edit_month));
          check_field("edit_year", 32'(want.edit_year), 32'(got.edit_year));
          check_field("brightness", 32'(want.brightness), 32'(got.brightness));
          check_field("clock_run", 32'(want.clock_run), 32'(got.clock_run));
          check_field("commit", 32'(want.commit), 32'(got.commit));
        end
      end
      if (in_valid && in_ready) begin
        got = advance_controller(in_data);
        views_due.push_back(cur_pinned ? cur_want : got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("[clock_set_mode_controller_core] ERROR");
        $finish;
      end
    end
  end

  // result side: random ready at a varying rate (100, 80, 50 or 20 percent), plus one long hold-off
  // that lets the output buffer fill and back-pressure the input
  initial begin : receiver
    int  n;
    int  pct;
    bit  held;
    n    = 0;
    pct  = 100;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 250) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 80;
          2: pct = 50;
          default: pct = 20;
        endcase
      end
      n++;
      out_ready <= ($urandom_range(1, 100) <= pct);
    end
  end

  initial begin : stimulus
    out_t        reset_view;
    int          left;
    int          burst;
    int          gap;
    logic [15:0] short_ms;
    logic [15:0] long_ms;
    logic [9:0]  tick;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_SHORT_TO;
    cfg_wdata    = '0;
    cur_pinned   = 1'b0;
    cur_want     = '0;
    mismatches   = 0;
    results_seen = 0;
    reset_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    reset_view = make_view(MODE_HIDDEN, FLD_HOURS, 0, 0, 0, 0, 1, 1, 0, 100, 1'b1,
                           COMMIT_NONE);
    add_row(plain(ACT_TICK), 1'b1, reset_view);
    add_row(plain(ACT_UNUSED_TOP), 1'b1, reset_view);
    add_row(make_event(ACT_SET_MODE, MODE_UNUSED_TOP, 5'd31, 6'd63, 6'd63, 3'd7, 5'd31,
                       4'd15, 7'd127), 1'b1, reset_view);
    add_row(plain(ACT_INC));
    add_row(plain(ACT_SET_MODE, MODE_BRIGHT), 1'b1,
            make_view(MODE_BRIGHT, FLD_HOURS, 0, 0, 0, 0, 1, 1, 0, 100, 1'b1, COMMIT_NONE));
    // brightness already at the top
    add_row(plain(ACT_INC), 1'b1,
            make_view(MODE_BRIGHT, FLD_HOURS, 0, 0, 0, 0, 1, 1, 0, 100, 1'b1, COMMIT_NONE));
    add_row(plain(ACT_DEC));
    // out-of-range current time saturates on load
    add_row(make_event(ACT_SET_MODE, MODE_SET_TIME, 5'd31, 6'd63, 6'd63, 3'd0, 5'd1,
                       4'd1, 7'd0), 1'b1,
            make_view(MODE_SET_TIME, FLD_HOURS, 23, 59, 59, 0, 1, 1, 0, 95, 1'b0,
                      COMMIT_NONE));
    add_row(plain(ACT_INC));
    add_row(plain(ACT_PREV_FLD));
    add_row(plain(ACT_DEC));
    add_row(plain(ACT_NEXT_FLD));
    add_row(plain(ACT_DEC));
    add_row(plain(ACT_ACCEPT));
    add_row(make_event(ACT_SET_MODE, MODE_SET_DATE, 5'd0, 6'd0, 6'd0, 3'd7, 5'd0,
                       4'd15, 7'd127), 1'b1,
            make_view(MODE_SET_DATE, FLD_WEEKDAY, 23, 59, 58, 6, 1, 12, 99, 95, 1'b0,
                      COMMIT_NONE));
    add_row(plain(ACT_INC));
    add_row(plain(ACT_PREV_FLD));
    add_row(plain(ACT_INC));
    // Feb 31 in a leap year loads unclamped, first edit pulls it to 29
    add_row(make_event(ACT_SET_MODE, MODE_SET_DATE, 5'd0, 6'd0, 6'd0, 3'd0, 5'd31,
                       4'd2, 7'd0), 1'b1,
            make_view(MODE_SET_DATE, FLD_WEEKDAY, 23, 59, 58, 0, 31, 2, 0, 95, 1'b0,
                      COMMIT_NONE));
    add_row(plain(ACT_NEXT_FLD));
    add_row(plain(ACT_DEC));
    add_row(plain(ACT_NEXT_FLD));
    add_row(plain(ACT_DEC));
    add_row(plain(ACT_DEC));
    add_row(plain(ACT_ACCEPT));
    add_row(plain(ACT_SET_MODE, MODE_DETAILS));
    add_row(plain(ACT_ACCEPT));
    add_row(plain(ACT_CANCEL));

    foreach (script[i]) offer(script[i].ev, script[i].pinned, script[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin short_ms = 16'd0;     long_ms = 16'd65535; tick = 10'd1000; end
        1: begin short_ms = 16'd65535; long_ms = 16'd0;     tick = 10'd1;    end
        2: begin short_ms = 16'd60;    long_ms = 16'd150;   tick = 10'd7;    end
        3: begin short_ms = 16'd300;   long_ms = 16'd500;   tick = 10'd25;   end
        default: begin short_ms = 16'd3500; long_ms = 16'd5000; tick = 10'd10; end
      endcase
      program_timeouts(short_ms, long_ms, tick);
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && left > 0) begin
          offer(rand_event(), 1'b0, '0);
          burst--;
          left--;
        end
        // phase 1 streams back to back
        gap = (ph == 1) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end

    settle();
    if (mismatches == 0 && views_due.size() == 0) begin
      $display("[clock_set_mode_controller_core] OK");
    end else begin
      $display("[clock_set_mode_controller_core] ERROR");
    end
    $finish;
  end

endmodule
